/* design/icpne_pkg.sv */
// shared constants, types and product tables for the icp normal-equation accumulator
package icpne_pkg;

  // frame size and fixed-point format
  localparam int MAX_PIXELS_LOG2 = 20;
  localparam int FRAC_BITS       = 16;
  localparam int DATA_W          = 24;
  localparam int CODE_W          = 3;
  localparam int ACC_W           = 64;
  localparam int ACC_FRAC        = 32;
  localparam int PROD_W          = 2 * DATA_W;
  localparam int COUNT_W         = MAX_PIXELS_LOG2 + 1;

  // operands: residual then six jacobian terms
  localparam int NUM_JAC  = 6;
  localparam int NUM_OPS  = NUM_JAC + 1;
  localparam int OP_IDX_W = $clog2(NUM_OPS);

  // result layout
  localparam int NUM_PRODUCTS = 28;
  localparam int NUM_SUMS     = 32;
  localparam int IDX_W        = $clog2(NUM_SUMS);
  localparam int IDX_GOOD     = 28;
  localparam int IDX_FAR      = 29;
  localparam int IDX_ANGLE    = 30;
  localparam int IDX_OTHER    = 31;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // status codes
  localparam logic [CODE_W-1:0] STATUS_GOOD  = 3'd0;
  localparam logic [CODE_W-1:0] STATUS_FAR   = 3'd4;
  localparam logic [CODE_W-1:0] STATUS_ANGLE = 3'd5;

  typedef enum logic [1:0] {
    CLS_GOOD,
    CLS_FAR,
    CLS_ANGLE,
    CLS_OTHER
  } cls_e;

  typedef logic [NUM_OPS-1:0][DATA_W-1:0] ops_t;

  typedef struct packed {
    cls_e cls;
    logic last;
    ops_t ops;
  } rec_t;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [COUNT_W-1:0]      count_t;

  // operand pair of each product sum: error squared, error times jacobian, jacobian upper triangle
  localparam logic [OP_IDX_W-1:0] OPA_IDX [NUM_PRODUCTS] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4,
    3'd5, 3'd5,
    3'd6
  };
  localparam logic [OP_IDX_W-1:0] OPB_IDX [NUM_PRODUCTS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
    3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
    3'd3, 3'd4, 3'd5, 3'd6,
    3'd4, 3'd5, 3'd6,
    3'd5, 3'd6,
    3'd6
  };

endpackage

/* design/icpne_if.sv */
// request channel interfaces for pixel records and result sums
interface icpne_in_if;
  import icpne_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CODE_W-1:0]        status_code;
  logic signed [DATA_W-1:0] residual;
  logic signed [DATA_W-1:0] jac_nx;
  logic signed [DATA_W-1:0] jac_ny;
  logic signed [DATA_W-1:0] jac_nz;
  logic signed [DATA_W-1:0] jac_cx;
  logic signed [DATA_W-1:0] jac_cy;
  logic signed [DATA_W-1:0] jac_cz;
  logic                     last_item;

  modport source (
    output valid, status_code, residual, jac_nx, jac_ny, jac_nz,
           jac_cx, jac_cy, jac_cz, last_item,
    input  ready
  );
  modport sink (
    input  valid, status_code, residual, jac_nx, jac_ny, jac_nz,
           jac_cx, jac_cy, jac_cz, last_item,
    output ready
  );
endinterface

interface icpne_out_if;
  import icpne_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        sum_index;
  logic signed [ACC_W-1:0] sum_value;
  logic                    last_sum;

  modport source (
    output valid, sum_index, sum_value, last_sum,
    input  ready
  );
  modport sink (
    input  valid, sum_index, sum_value, last_sum,
    output ready
  );
endinterface

/* design/icp_normal_equation_accumulator_core.sv */
// top level of the icp point-to-plane normal-equation accumulator
// Takes one tracking record per cycle (status, residual, six jacobian terms, all signed Q7.16)
// and builds the 28 products of a good record (error squared, error times jacobian, the
// upper triangle of the jacobian outer product) into saturating 64-bit Q.32 sums, while
// counting good pixels, too-far rejects, normal-mismatch rejects and other failures in
// saturating 21-bit counters. A record flagged last_item is accumulated like any other and
// then closes the frame: its 32 totals (indices 0-27 sums, 28-31 counts) leave in index
// order on the result channel, one request per cycle while the receiver is ready, with
// last_sum on index 31, and all sums and counts restart from zero. Sustained rate is one
// record per cycle while no last record waits at the accumulators; a record is written into
// the queue on its accepting edge, then passes through the product register to the
// accumulators. The drain bank loads on the same edge that the last record reaches the
// accumulators, and then offers the frame's first total. Totals drain from a separate bank, so
// records keep flowing while results are stalled; only the next frame's last record waits at
// the accumulators until all 32 totals of the previous frame have been taken.
module icp_normal_equation_accumulator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  icpne_in_if.sink    item_i,
  icpne_out_if.source sum_o
);
  import icpne_pkg::*;

  // front to queue
  logic  push_valid, push_ready;
  rec_t  push_rec;

  // queue to back end
  logic  pop_valid, pop_ready;
  rec_t  pop_rec;

  // back end to drain bank
  logic  load, snap_free;
  acc_t  snap [NUM_SUMS];

  // classify status and pack operands
  icpne_front u_front (
    .item_i       (item_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_rec_o   (push_rec)
  );

  // decouples acceptance from the arithmetic pipeline
  icpne_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_rec_o    (pop_rec)
  );

  // 28 multiplier lanes, then saturating accumulators and counters
  icpne_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_rec_i   (pop_rec),
    .snap_free_i (snap_free),
    .load_o      (load),
    .snap_o      (snap)
  );

  // holds one frame of totals and serializes them
  icpne_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .snap_i      (snap),
    .snap_free_o (snap_free),
    .sum_o       (sum_o)
  );

endmodule

/* design/icpne_front.sv */
// front end: accepts pixel records and classifies them by status
module icpne_front (
  icpne_in_if.sink         item_i,
  input  logic             push_ready_i,
  output logic             push_valid_o,
  output icpne_pkg::rec_t  push_rec_o
);
  import icpne_pkg::*;

  cls_e cls;

  always_comb begin
    case (item_i.status_code)
      STATUS_GOOD:  cls = CLS_GOOD;
      STATUS_FAR:   cls = CLS_FAR;
      STATUS_ANGLE: cls = CLS_ANGLE;
      default:      cls = CLS_OTHER;
    endcase
  end

  assign item_i.ready = push_ready_i;
  assign push_valid_o = item_i.valid;

  always_comb begin
    push_rec_o.cls    = cls;
    push_rec_o.last   = item_i.last_item;
    push_rec_o.ops[0] = item_i.residual;
    push_rec_o.ops[1] = item_i.jac_nx;
    push_rec_o.ops[2] = item_i.jac_ny;
    push_rec_o.ops[3] = item_i.jac_nz;
    push_rec_o.ops[4] = item_i.jac_cx;
    push_rec_o.ops[5] = item_i.jac_cy;
    push_rec_o.ops[6] = item_i.jac_cz;
  end

endmodule

/* design/icpne_queue.sv */
// short record queue between the front end and the arithmetic back end
module icpne_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  icpne_pkg::rec_t push_rec_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output icpne_pkg::rec_t pop_rec_o
);
  import icpne_pkg::*;

  rec_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_rec_o    = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

/* design/icpne_back.sv */
// back end: product stage and saturating accumulation of sums and counts
module icpne_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  icpne_pkg::rec_t pop_rec_i,
  input  logic            snap_free_i,
  output logic            load_o,
  output icpne_pkg::acc_t snap_o [icpne_pkg::NUM_SUMS]
);
  import icpne_pkg::*;

  // product carries 2*FRAC_BITS fraction bits, sums carry ACC_FRAC
  localparam bit   SCALE_UP = (2 * FRAC_BITS <= ACC_FRAC);
  localparam int   SH_L     = SCALE_UP ? (ACC_FRAC - 2 * FRAC_BITS) : 0;
  localparam int   SH_R     = SCALE_UP ? 1 : (2 * FRAC_BITS - ACC_FRAC);
  localparam acc_t RND      = acc_t'(1) <<< (SH_R - 1);
  localparam acc_t ACC_MAX  = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam acc_t ACC_MIN  = {1'b1, {(ACC_W - 1){1'b0}}};

  function automatic acc_t sat_add(acc_t a, acc_t b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return acc_t'(s[ACC_W-1:0]);
  endfunction

  function automatic count_t sat_inc(count_t c);
    return (c == '1) ? c : c + COUNT_W'(1);
  endfunction

  acc_t   prod_d [NUM_PRODUCTS];
  acc_t   m_prod_q [NUM_PRODUCTS];
  logic   m_valid_q;
  cls_e   m_cls_q;
  logic   m_last_q;
  logic   m_ready, acc_fire;

  acc_t   acc_q [NUM_PRODUCTS];
  acc_t   acc_upd [NUM_PRODUCTS];
  count_t good_q, far_q, angle_q, other_q;
  count_t good_upd, far_upd, angle_upd, other_upd;

  // multiplier lanes, one per product sum
  for (genvar k = 0; k < NUM_PRODUCTS; k++) begin : g_mul
    logic signed [DATA_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    acc_t                     ext;

    assign op_a      = pop_rec_i.ops[OPA_IDX[k]];
    assign op_b      = pop_rec_i.ops[OPB_IDX[k]];
    assign prod      = op_a * op_b;
    assign ext       = ACC_W'(prod);
    assign prod_d[k] = SCALE_UP ? (ext <<< SH_L) : ((ext + RND) >>> SH_R);
  end

  assign acc_fire    = m_valid_q && (!m_last_q || snap_free_i);
  assign m_ready     = !m_valid_q || acc_fire;
  assign pop_ready_o = m_ready;
  assign load_o      = acc_fire && m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_ready) begin
      m_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_ready && pop_valid_i) begin
      m_prod_q <= prod_d;
      m_cls_q  <= pop_rec_i.cls;
      m_last_q <= pop_rec_i.last;
    end
  end

  // accumulation lanes
  always_comb begin
    for (int k = 0; k < NUM_PRODUCTS; k++) begin
      acc_upd[k] = (m_cls_q == CLS_GOOD) ? sat_add(acc_q[k], m_prod_q[k]) : acc_q[k];
    end
    good_upd  = (m_cls_q == CLS_GOOD)  ? sat_inc(good_q)  : good_q;
    far_upd   = (m_cls_q == CLS_FAR)   ? sat_inc(far_q)   : far_q;
    angle_upd = (m_cls_q == CLS_ANGLE) ? sat_inc(angle_q) : angle_q;
    other_upd = (m_cls_q == CLS_OTHER) ? sat_inc(other_q) : other_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_PRODUCTS; k++) begin
        acc_q[k] <= '0;
      end
      good_q  <= '0;
      far_q   <= '0;
      angle_q <= '0;
      other_q <= '0;
    end else if (acc_fire) begin
      for (int k = 0; k < NUM_PRODUCTS; k++) begin
        acc_q[k] <= m_last_q ? '0 : acc_upd[k];
      end
      good_q  <= m_last_q ? '0 : good_upd;
      far_q   <= m_last_q ? '0 : far_upd;
      angle_q <= m_last_q ? '0 : angle_upd;
      other_q <= m_last_q ? '0 : other_upd;
    end
  end

  // frame totals handed to the drain bank
  always_comb begin
    for (int k = 0; k < NUM_PRODUCTS; k++) begin
      snap_o[k] = acc_upd[k];
    end
    snap_o[IDX_GOOD]  = ACC_W'(good_upd);
    snap_o[IDX_FAR]   = ACC_W'(far_upd);
    snap_o[IDX_ANGLE] = ACC_W'(angle_upd);
    snap_o[IDX_OTHER] = ACC_W'(other_upd);
  end

endmodule

/* design/icpne_drain.sv */
// frame total bank that streams the 32 sums out one request at a time
module icpne_drain (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  icpne_pkg::acc_t  snap_i [icpne_pkg::NUM_SUMS],
  output logic             snap_free_o,
  icpne_out_if.source      sum_o
);
  import icpne_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SUMS - 1);

  acc_t             snap_q [NUM_SUMS];
  logic [IDX_W-1:0] idx_q;
  logic             busy_q;
  logic             take, fin;

  assign take        = busy_q && sum_o.ready;
  assign fin         = take && (idx_q == LAST_IDX);
  assign snap_free_o = !busy_q || fin;

  assign sum_o.valid     = busy_q;
  assign sum_o.sum_index = idx_q;
  assign sum_o.sum_value = snap_q[idx_q];
  assign sum_o.last_sum  = (idx_q == LAST_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      busy_q <= !fin;
      idx_q  <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= snap_i;
    end
  end

endmodule

/* design/icpne_checker.sv */
// port-level checks on the result stream of the accumulator, bound to the top level
module icpne_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [icpne_pkg::IDX_W-1:0]    sum_index_i,
  input logic signed [icpne_pkg::ACC_W-1:0] sum_value_i,
  input logic                           last_sum_i
);
  import icpne_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SUMS - 1);

  // stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sum_index_i)
      && $stable(sum_value_i) && $stable(last_sum_i))
    else $error("result changed while stalled");

  // within a frame the indices follow back to back
  a_index_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (sum_index_i != LAST_IDX) |=>
      out_valid_i && (sum_index_i == IDX_W'($past(sum_index_i) + IDX_W'(1))))
    else $error("frame totals not contiguous");

  // last flag marks exactly the final index
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_sum_i == (sum_index_i == LAST_IDX)))
    else $error("last_sum does not match final index");

  // a new frame starts at index zero
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_sum_i |=> !out_valid_i || (sum_index_i == '0))
    else $error("frame did not restart at index zero");

endmodule

bind icp_normal_equation_accumulator_core icpne_checker u_icpne_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (sum_o.valid),
  .out_ready_i (sum_o.ready),
  .sum_index_i (sum_o.sum_index),
  .sum_value_i (sum_o.sum_value),
  .last_sum_i  (sum_o.last_sum)
);

/* tb/sv/icp_normal_equation_accumulator_core_test.sv */
// self-checking testbench for the icp normal-equation accumulator core
module icp_normal_equation_accumulator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import icpne_pkg::*;

  // status codes the package leaves unnamed
  localparam logic [CODE_W-1:0] ST_BAD_NORMAL = 3'd1;
  localparam logic [CODE_W-1:0] ST_OUTSIDE    = 3'd2;
  localparam logic [CODE_W-1:0] ST_BAD_REF    = 3'd3;
  localparam logic [CODE_W-1:0] ST_UNKNOWN6   = 3'd6;
  localparam logic [CODE_W-1:0] ST_UNKNOWN7   = 3'd7;

  // operand corner values
  localparam logic [DATA_W-1:0] OP_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] OP_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] OP_ZERO = '0;
  localparam logic [DATA_W-1:0] OP_ONES = '1;
  localparam logic [DATA_W-1:0] OP_LSB  = {{(DATA_W-1){1'b0}}, 1'b1};

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // run shape
  localparam int RANDOM_ITEMS  = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 12;

  typedef struct packed {
    logic [CODE_W-1:0] status;
    logic              last;
    ops_t              ops;     // ops[0] residual, ops[1..6] jacobian terms
  } pixel_rec_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    acc_t             value;
    logic             last;
  } frame_sum_t;

  // running frame totals and the sums a closed frame must produce
  class frame_sum_scoreboard;
    acc_t         sums [NUM_PRODUCTS];
    count_t       good_cnt;
    count_t       far_cnt;
    count_t       angle_cnt;
    count_t       other_cnt;
    frame_sum_t   frame_totals [$];
    int unsigned  errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (sums[k]) sums[k] = '0;
      good_cnt  = '0;
      far_cnt   = '0;
      angle_cnt = '0;
      other_cnt = '0;
    endfunction

    function count_t bump(count_t c);
      return (&c) ? c : c + COUNT_W'(1);
    endfunction

    // bring a 2*FRAC_BITS product to the 32 fraction bits of the sums
    function acc_t scale_product(longint p);
      int     sh;
      longint q;
      if (2 * FRAC_BITS <= ACC_FRAC) begin
        return p <<< (ACC_FRAC - 2 * FRAC_BITS);
      end
      sh = 2 * FRAC_BITS - ACC_FRAC;
      q  = p + (longint'(1) <<< (sh - 1));
      return q >>> sh;
    endfunction

    function acc_t sat_add(acc_t a, acc_t b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
        return s[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_W-1:0];
    endfunction

    function void note_record(pixel_rec_t r);
      int k;
      k = 0;
      if (r.status == STATUS_GOOD) begin
        // error squared, error times jacobian, then the jacobian upper triangle
        for (int a = 0; a < NUM_OPS; a++) begin
          for (int b = a; b < NUM_OPS; b++) begin
            sums[k] = sat_add(sums[k], scale_product(longint'($signed(r.ops[a])) *
                                                     longint'($signed(r.ops[b]))));
            k++;
          end
        end
        good_cnt = bump(good_cnt);
      end else if (r.status == STATUS_FAR) begin
        far_cnt = bump(far_cnt);
      end else if (r.status == STATUS_ANGLE) begin
        angle_cnt = bump(angle_cnt);
      end else begin
        other_cnt = bump(other_cnt);
      end
      if (r.last) begin
        for (int i = 0; i < NUM_SUMS; i++) begin
          frame_sum_t t;
          t.index = IDX_W'(i);
          t.last  = (i == IDX_OTHER);
          if (i < NUM_PRODUCTS)   t.value = sums[i];
          else if (i == IDX_GOOD) t.value = acc_t'(good_cnt);
          else if (i == IDX_FAR)  t.value = acc_t'(far_cnt);
          else if (i == IDX_ANGLE) t.value = acc_t'(angle_cnt);
          else                    t.value = acc_t'(other_cnt);
          frame_totals.push_back(t);
        end
        clear_frame();
      end
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_sum(logic [IDX_W-1:0] index, acc_t value, logic last);
      frame_sum_t t;
      if (frame_totals.size() == 0) begin
        report($sformatf("sum %0d = %0d arrived with no frame closed", index, value));
        return;
      end
      t = frame_totals.pop_front();
      if (index !== t.index)
        report($sformatf("sum_index %0d, wanted %0d", index, t.index));
      if (value !== t.value)
        report($sformatf("sum %0d value %0d, wanted %0d", t.index, value, t.value));
      if (last !== t.last)
        report($sformatf("sum %0d last_sum %b, wanted %b", t.index, last, t.last));
    endtask

    function int pending();
      return frame_totals.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  icpne_in_if  item_if ();
  icpne_out_if sum_if ();

  icp_normal_equation_accumulator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .sum_o  (sum_if)
  );

  frame_sum_scoreboard sb;
  int burst_left;
  bit pressure_go;

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- stimulus helpers

  function automatic pixel_rec_t make_record(logic [CODE_W-1:0] st, ops_t ops, logic lst);
    pixel_rec_t r;
    r.status = st;
    r.ops    = ops;
    r.last   = lst;
    return r;
  endfunction

  // full-range and small values, with the corners showing up often
  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(0, 9))
      0:       return OP_MAX;
      1:       return OP_MIN;
      2:       return OP_ZERO;
      3:       return OP_ONES;
      4:       return DATA_W'($urandom_range(0, 255));
      5:       return -DATA_W'($urandom_range(0, 255));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic ops_t random_ops();
    ops_t ops;
    for (int k = 0; k < NUM_OPS; k++) ops[k] = random_operand();
    return ops;
  endfunction

  // good records dominate unless the frame is a run of rejects
  function automatic pixel_rec_t random_record(logic lst, bit fail_only);
    logic [CODE_W-1:0] st;
    if (!fail_only && $urandom_range(0, 9) < 6) st = STATUS_GOOD;
    else st = CODE_W'($urandom_range(ST_BAD_NORMAL, ST_UNKNOWN7));
    return make_record(st, random_ops(), lst);
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_record(pixel_rec_t r);
    item_if.valid       <= 1'b1;
    item_if.status_code <= r.status;
    item_if.residual    <= r.ops[0];
    item_if.jac_nx      <= r.ops[1];
    item_if.jac_ny      <= r.ops[2];
    item_if.jac_nz      <= r.ops[3];
    item_if.jac_cx      <= r.ops[4];
    item_if.jac_cy      <= r.ops[5];
    item_if.jac_cz      <= r.ops[6];
    item_if.last_item   <= r.last;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    sb.note_record(r);
  endtask

  task automatic idle_gap(int n);
    item_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // bursts of random length, a random gap after each; long bursts now and then
  task automatic paced_send(pixel_rec_t r);
    send_record(r);
    burst_left--;
    if (burst_left <= 0) begin
      idle_gap($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // ---------------------------------------------------------------- result side

  // receiver: one long hold-off when asked, otherwise a stall pattern that changes mode
  initial begin
    int unsigned cyc;
    int          mode;
    bit          held;
    cyc  = 0;
    mode = 0;
    held = 1'b0;
    sum_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pressure_go && !held) begin
        // block fills and pushes back on the record channel meanwhile
        held = 1'b1;
        sum_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (cyc % 48 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       sum_if.ready <= 1'b1;
        1:       sum_if.ready <= 1'($urandom_range(0, 1));
        2:       sum_if.ready <= ($urandom_range(0, 3) != 0);
        default: sum_if.ready <= (cyc % 5 == 0);
      endcase
      cyc++;
    end
  end

  // every taken sum goes straight to the checker
  always @(posedge clk_i) begin
    if (sum_if.valid === 1'b1 && sum_if.ready === 1'b1) begin
      sb.check_sum(sum_if.sum_index, sum_if.sum_value, sum_if.last_sum);
    end
  end

  // watchdog: too long with no request taken on either side ends the run
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
          (sum_if.valid === 1'b1 && sum_if.ready === 1'b1)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int sent;
    int frame_len;
    bit fail_only;
    sb          = new();
    pressure_go = 1'b0;
    burst_left  = 4;
    rst_ni              <= 1'b0;
    item_if.valid       <= 1'b0;
    item_if.status_code <= STATUS_GOOD;
    item_if.residual    <= '0;
    item_if.jac_nx      <= '0;
    item_if.jac_ny      <= '0;
    item_if.jac_nz      <= '0;
    item_if.jac_cx      <= '0;
    item_if.jac_cy      <= '0;
    item_if.jac_cz      <= '0;
    item_if.last_item   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner operands, then every status code in one frame
    paced_send(make_record(STATUS_GOOD, {NUM_OPS{OP_MAX}}, 1'b0));
    paced_send(make_record(STATUS_GOOD, {NUM_OPS{OP_MIN}}, 1'b0));
    paced_send(make_record(STATUS_GOOD,
                           {OP_MIN, OP_MAX, OP_MIN, OP_MAX, OP_MIN, OP_MAX, OP_MIN}, 1'b0));
    paced_send(make_record(STATUS_GOOD, {NUM_OPS{OP_ONES}}, 1'b0));
    paced_send(make_record(ST_BAD_NORMAL, random_ops(), 1'b0));
    paced_send(make_record(ST_OUTSIDE, random_ops(), 1'b0));
    paced_send(make_record(ST_BAD_REF, random_ops(), 1'b0));
    paced_send(make_record(STATUS_FAR, random_ops(), 1'b0));
    paced_send(make_record(STATUS_ANGLE, random_ops(), 1'b0));
    // unknown codes count as other failures
    paced_send(make_record(ST_UNKNOWN6, random_ops(), 1'b0));
    paced_send(make_record(ST_UNKNOWN7, random_ops(), 1'b1));
    // single-record frames back to back, then a two-record frame
    paced_send(make_record(STATUS_GOOD, {NUM_OPS{OP_ZERO}}, 1'b1));
    paced_send(make_record(STATUS_FAR, random_ops(), 1'b1));
    paced_send(make_record(STATUS_ANGLE, random_ops(), 1'b1));
    paced_send(make_record(STATUS_GOOD, {NUM_OPS{OP_LSB}}, 1'b1));
    paced_send(make_record(STATUS_GOOD,
                           {OP_LSB, OP_ONES, OP_LSB, OP_ONES, OP_MAX, OP_MIN, OP_LSB}, 1'b1));
    paced_send(make_record(STATUS_GOOD, random_ops(), 1'b0));
    paced_send(make_record(STATUS_GOOD, random_ops(), 1'b1));

    // random frames, with one long receiver hold-off at the start
    pressure_go = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      frame_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
      fail_only = ($urandom_range(0, 7) == 0);
      for (int n = 0; n < frame_len; n++) begin
        paced_send(random_record(n == frame_len - 1, fail_only));
      end
      sent += frame_len;
    end
    item_if.valid <= 1'b0;

    // drain, then give the pipeline time to show any stray sum
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
